### design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SBR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SBR_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

### design/sbr_pkg.sv
`default_nettype none
package sbr_pkg;

	localparam int NOISE_W   = 32;
	localparam int CNT_W     = 14;
	localparam int LEVEL_W   = 22;
	localparam int DIFF_W    = 23;
	localparam int COEF_W    = 14;
	localparam int PROD_W    = 37;
	localparam int LEN_W     = 17;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 4;

	localparam logic [NOISE_W-1:0] NOISE_TAPS   = 32'hA300_0000;
	localparam logic [NOISE_W-1:0] NOISE_A_INIT = 32'hA300_5670;
	localparam logic [NOISE_W-1:0] NOISE_B_INIT = 32'h6A10_D2BE;

	localparam logic signed [LEVEL_W-1:0] FULL_SCALE  = 22'sd1048576;
	localparam logic signed [COEF_W-1:0]  SMOOTH_COEF = 14'sd6128;

	localparam logic [LEN_W-1:0] MIN_LOOP = 17'd64;

	localparam logic [CFG_W-1:0]     FILTER_SIZE_RST = 4'd5;
	localparam logic [CFG_W-1:0]     FILTER_SIZE_MAX = 4'd10;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FILTER  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FILTER = 4'd1;

	typedef struct packed {
		logic mul_first;
		logic mul_second;
		logic upd_first;
		logic upd_second;
		logic gate;
		logic target_hi;
	} smooth_ctl_t;

	function automatic logic [CNT_W-1:0] mask_of(input logic [CFG_W-1:0] size);
		logic [CFG_W-1:0] k;
		logic [CNT_W:0]   w;
		k = (size > FILTER_SIZE_MAX) ? FILTER_SIZE_MAX : size;
		w = (CNT_W+1)'(1) << ({1'b0, k} + 5'd4);
		return CNT_W'(w - (CNT_W+1)'(1));
	endfunction

	function automatic logic [NOISE_W-1:0] noise_next(input logic [NOISE_W-1:0] r);
		return (r >> 1) ^ (r[0] ? NOISE_TAPS : '0);
	endfunction

endpackage
`default_nettype wire

### design/sbr_loop_mem.sv
`default_nettype none
module sbr_loop_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic          wdata,
	input  wire logic [AW-1:0] raddr,
	output logic               rdata
);

	logic mem_q [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### design/sbr_rem_unit.sv
`default_nettype none
`include "assert_macros.svh"
module sbr_rem_unit #(
	parameter int AW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [AW-1:0] dividend,
	input  wire logic [AW:0]   divisor,
	output logic               done,
	output logic [AW-1:0]      rem
);

	localparam int CW = $clog2(AW + 1);

	logic [AW:0]   rem_q;
	logic [AW:0]   div_q;
	logic [AW-1:0] num_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [AW:0]   trial;
	logic [AW:0]   rem_next;

	always_comb begin
		trial    = {rem_q[AW-1:0], num_q[AW-1]};
		rem_next = (trial >= div_q) ? trial - div_q : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(AW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			num_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= num_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[AW-1:0];

	`SBR_ASSERT_IMPL(a_rem_below_div, clk, arst_n, done_q, rem_q < div_q, "remainder not below divisor")

endmodule
`default_nettype wire

### design/sbr_smooth_unit.sv
`default_nettype none
`include "assert_macros.svh"
module sbr_smooth_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire sbr_pkg::smooth_ctl_t                 ctl,
	output logic signed [sbr_pkg::LEVEL_W-1:0]        level
);

	logic signed [sbr_pkg::LEVEL_W-1:0] sf_q;
	logic signed [sbr_pkg::LEVEL_W-1:0] ss_q;
	logic signed [sbr_pkg::PROD_W-1:0]  prod_q;
	logic signed [sbr_pkg::LEVEL_W-1:0] target;
	logic signed [sbr_pkg::DIFF_W-1:0]  diff;
	logic signed [sbr_pkg::PROD_W-1:0]  prod;
	logic signed [sbr_pkg::LEVEL_W-1:0] delta;

	always_comb begin
		target = ctl.target_hi ? sbr_pkg::FULL_SCALE : -sbr_pkg::FULL_SCALE;
		if (ctl.mul_first) begin
			diff = ctl.gate ? sbr_pkg::DIFF_W'(target) - sbr_pkg::DIFF_W'(sf_q)
				: -sbr_pkg::DIFF_W'(sf_q);
		end else begin
			diff = ctl.gate ? sbr_pkg::DIFF_W'(sf_q) - sbr_pkg::DIFF_W'(ss_q)
				: -sbr_pkg::DIFF_W'(ss_q);
		end
		prod  = diff * sbr_pkg::SMOOTH_COEF;
		delta = {prod_q[sbr_pkg::PROD_W-1], prod_q[sbr_pkg::PROD_W-1:16]};
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_first || ctl.mul_second) begin
			prod_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= '0;
			ss_q <= '0;
		end else begin
			if (ctl.upd_first) begin
				sf_q <= sf_q + delta;
			end
			if (ctl.upd_second) begin
				ss_q <= ss_q + delta;
			end
		end
	end

	assign level = ss_q;

	`SBR_ASSERT(a_first_range, clk, arst_n, (sf_q <= sbr_pkg::FULL_SCALE) && (sf_q >= -sbr_pkg::FULL_SCALE), "first stage out of range")
	`SBR_ASSERT(a_second_range, clk, arst_n, (ss_q <= sbr_pkg::FULL_SCALE) && (ss_q >= -sbr_pkg::FULL_SCALE), "second stage out of range")

endmodule
`default_nettype wire

### design/stochastic_bitstream_resonator.sv
// channel  direction  handshake              payload
// in       to block   in_valid / in_stall    delay_length, gate
// out      from block out_valid / out_stall  level
// cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample first computes its loop position with a bit-serial remainder, then runs each
// of its STEPS_PER_SAMPLE bit-steps through the states RD, EX, F1, M2 and F2 on the shared
// smoothing multiplier. After reset a clearing pass writes zero to all LOOP_DEPTH loop
// bits, one per cycle, with in_stall high; configuration writes are taken meanwhile.
// A finished level waits in the output register while the next sample is taken.
`default_nettype none
`include "assert_macros.svh"
module stochastic_bitstream_resonator #(
	parameter int LOOP_DEPTH       = 65536,
	parameter int STEPS_PER_SAMPLE = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [sbr_pkg::LEN_W-1:0]            delay_length,
	input  wire logic                                 gate,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [sbr_pkg::LEVEL_W-1:0]        level,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [sbr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [sbr_pkg::CFG_W-1:0]            cfg_data
);

	localparam int AW = $clog2(LOOP_DEPTH);
	localparam int LW = AW + 1;
	localparam int SW = $clog2(STEPS_PER_SAMPLE + 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MOD   = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_EX    = 4'd4;
	localparam logic [3:0] ST_F1    = 4'd5;
	localparam logic [3:0] ST_M2    = 4'd6;
	localparam logic [3:0] ST_F2    = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0]                   state_q;
	logic [AW-1:0]                clr_q;
	logic [AW-1:0]                pos_q;
	logic [LW-1:0]                len_q;
	logic                         gate_q;
	logic [SW-1:0]                step_q;
	logic [sbr_pkg::CFG_W-1:0]    size_a_q;
	logic [sbr_pkg::CFG_W-1:0]    size_b_q;
	logic [sbr_pkg::CNT_W-1:0]    mask_a_q;
	logic [sbr_pkg::CNT_W-1:0]    mask_b_q;
	logic [sbr_pkg::NOISE_W-1:0]  noise_a_q;
	logic [sbr_pkg::NOISE_W-1:0]  noise_b_q;
	logic [sbr_pkg::CNT_W-1:0]    cnt_a_q;
	logic [sbr_pkg::CNT_W-1:0]    cnt_b_q;
	logic                         out_valid_q;
	logic signed [sbr_pkg::LEVEL_W-1:0] level_q;

	logic                         in_accept;
	logic [sbr_pkg::LEN_W-1:0]    len_clamp;
	logic                         rem_done;
	logic [AW-1:0]                rem;
	logic                         loop_out;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	logic                         mem_wdata;
	logic                         bit_a;
	logic                         bit_b;
	logic [sbr_pkg::CNT_W:0]      inc_a;
	logic [sbr_pkg::CNT_W:0]      inc_b;
	logic [sbr_pkg::CNT_W-1:0]    cnt_a_next;
	logic [sbr_pkg::CNT_W-1:0]    cnt_b_next;
	logic [LW-1:0]                pos_inc;
	logic                         out_free;
	logic signed [sbr_pkg::LEVEL_W-1:0] smooth_level;
	sbr_pkg::smooth_ctl_t         smooth_ctl;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		len_clamp = delay_length;
		if (delay_length < sbr_pkg::MIN_LOOP) begin
			len_clamp = sbr_pkg::MIN_LOOP;
		end
		if (delay_length > sbr_pkg::LEN_W'(LOOP_DEPTH)) begin
			len_clamp = sbr_pkg::LEN_W'(LOOP_DEPTH);
		end
	end

	always_comb begin
		bit_a = (noise_a_q[sbr_pkg::CNT_W-1:0] & mask_a_q) < cnt_a_q;
		bit_b = (noise_b_q[sbr_pkg::CNT_W-1:0] & mask_b_q) < cnt_b_q;
		inc_a = {1'b0, cnt_a_q} + (sbr_pkg::CNT_W+1)'(1);
		inc_b = {1'b0, cnt_b_q} + (sbr_pkg::CNT_W+1)'(1);
		cnt_a_next = cnt_a_q;
		if (loop_out && !bit_b) begin
			cnt_a_next = (inc_a < {1'b0, mask_a_q}) ? inc_a[sbr_pkg::CNT_W-1:0] : mask_a_q;
		end else if (!loop_out && bit_b) begin
			cnt_a_next = (cnt_a_q != '0) ? cnt_a_q - sbr_pkg::CNT_W'(1) : '0;
		end
		cnt_b_next = cnt_b_q;
		if (bit_a && !bit_b) begin
			cnt_b_next = (inc_b < {1'b0, mask_b_q}) ? inc_b[sbr_pkg::CNT_W-1:0] : mask_b_q;
		end else if (!bit_a && bit_b) begin
			cnt_b_next = (cnt_b_q != '0) ? cnt_b_q - sbr_pkg::CNT_W'(1) : '0;
		end
		pos_inc = {1'b0, pos_q} + LW'(1);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = 1'b0;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
		end else if (state_q == ST_EX) begin
			mem_we    = 1'b1;
			mem_wdata = gate_q ? bit_b : noise_b_q[0];
		end
	end

	always_comb begin
		smooth_ctl            = '0;
		smooth_ctl.gate       = gate_q;
		smooth_ctl.target_hi  = bit_b;
		smooth_ctl.mul_first  = (state_q == ST_EX);
		smooth_ctl.upd_first  = (state_q == ST_F1);
		smooth_ctl.mul_second = (state_q == ST_M2);
		smooth_ctl.upd_second = (state_q == ST_F2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_a_q <= sbr_pkg::FILTER_SIZE_RST;
			size_b_q <= sbr_pkg::FILTER_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sbr_pkg::CFG_FIRST_FILTER:  size_a_q <= cfg_data;
				sbr_pkg::CFG_SECOND_FILTER: size_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pos_q       <= '0;
			step_q      <= '0;
			noise_a_q   <= sbr_pkg::NOISE_A_INIT;
			noise_b_q   <= sbr_pkg::NOISE_B_INIT;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(LOOP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						step_q  <= '0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (rem_done) begin
						pos_q   <= rem;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					noise_a_q <= sbr_pkg::noise_next(noise_a_q);
					noise_b_q <= sbr_pkg::noise_next(noise_b_q);
					state_q   <= ST_EX;
				end
				ST_EX: begin
					if (gate_q) begin
						cnt_a_q <= cnt_a_next;
						cnt_b_q <= cnt_b_next;
					end
					state_q <= ST_F1;
				end
				ST_F1: state_q <= ST_M2;
				ST_M2: state_q <= ST_F2;
				ST_F2: begin
					pos_q  <= (pos_inc == len_q) ? '0 : pos_inc[AW-1:0];
					step_q <= step_q + SW'(1);
					state_q <= (step_q == SW'(STEPS_PER_SAMPLE - 1)) ? ST_OUT : ST_RD;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			len_q    <= len_clamp[LW-1:0];
			gate_q   <= gate;
			mask_a_q <= sbr_pkg::mask_of(size_a_q);
			mask_b_q <= sbr_pkg::mask_of(size_b_q);
		end
		if (state_q == ST_OUT && out_free) begin
			level_q <= smooth_level;
		end
	end

	sbr_loop_mem #(
		.DEPTH (LOOP_DEPTH),
		.AW    (AW)
	) u_loop_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (pos_q),
		.rdata (loop_out)
	);

	sbr_rem_unit #(
		.AW (AW)
	) u_rem_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.dividend (pos_q),
		.divisor  (len_clamp[LW-1:0]),
		.done     (rem_done),
		.rem      (rem)
	);

	sbr_smooth_unit u_smooth_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (smooth_ctl),
		.level  (smooth_level)
	);

	`SBR_ASSERT_IMPL(a_pos_in_loop, clk, arst_n,
		(state_q == ST_RD) || (state_q == ST_EX) || (state_q == ST_F2),
		({1'b0, pos_q} < len_q), "loop position outside active length")
	`SBR_ASSERT_IMPL(a_step_bound, clk, arst_n, (state_q == ST_F2),
		step_q < SW'(STEPS_PER_SAMPLE), "bit-step count overrun")
	`SBR_ASSERT_IMPL(a_out_from_seq, clk, arst_n, $rose(out_valid_q),
		$past(state_q == ST_OUT), "result beat raised outside output state")

endmodule
`default_nettype wire
